[rtl/pip_pkg.sv]
package pip_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_MWAIT,
        S_CHECK,
        S_ANGLE,
        S_MAG,
        S_JUDGE,
        S_EMIT
    } pip_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_NORM,
        C_ROT,
        C_DONE
    } cordic_state_t;

    typedef enum logic [1:0] {
        PROD_AX_BY,
        PROD_BX_AY,
        PROD_AX_BX,
        PROD_AY_BY
    } prod_sel_t;

    typedef struct packed {
        logic        done;
        logic [31:0] angle;
    } cordic_res_t;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    localparam logic [2:0] STATUS_OUTSIDE    = 3'd0;
    localparam logic [2:0] STATUS_TOUCH      = 3'd1;
    localparam logic [2:0] STATUS_INSIDE     = 3'd2;
    localparam logic [2:0] STATUS_UNDET      = 3'd3;
    localparam logic [2:0] STATUS_NOT_CLOSED = 3'd4;

    localparam logic REG_CLOSE_TOL = 1'b0;
    localparam logic REG_ANGLE_TOL = 1'b1;

    localparam logic [15:0] CLOSE_TOL_RESET = 16'd1;
    localparam logic [30:0] ANGLE_TOL_RESET = 31'd683565;

    localparam int CORDIC_W       = 64;
    localparam int NORM_LIMIT_BIT = 60;
    localparam int NORM_COARSE    = 8;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/pip_mac.sv]
module pip_mac
    import pip_pkg::*;
#(
    parameter int DW = 33
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [DW-1:0]   a,
    input  logic signed [DW-1:0]   b,
    output logic                   done,
    output logic signed [2*DW-1:0] product
);

    localparam int DIG = (DW + 31) / 32;
    localparam int MW  = DIG * 32;
    localparam int AW  = 2 * MW;
    localparam int PW  = 2 * DW;
    localparam int IW  = (DIG > 1) ? $clog2(DIG) : 1;
    localparam logic [IW-1:0] LAST_DIG = IW'(DIG - 1);

    logic              busy_reg, busy_next;
    logic [IW-1:0]     ia_reg, ia_next;
    logic [IW-1:0]     ib_reg, ib_next;
    logic [MW-1:0]     mag_a_reg, mag_a_next;
    logic [MW-1:0]     mag_b_reg, mag_b_next;
    logic              neg_reg, neg_next;
    logic [63:0]       prod_reg, prod_next;
    logic [IW:0]       pshift_reg, pshift_next;
    logic              pvalid_reg, pvalid_next;
    logic              plast_reg, plast_next;
    logic              sign_reg, sign_next;
    logic [AW-1:0]     acc_reg, acc_next;
    logic              done_reg, done_next;
    logic [PW-1:0]     product_reg, product_next;

    logic [DW-1:0]     abs_a;
    logic [DW-1:0]     abs_b;
    logic              issue_last;
    logic [31:0]       dig_a;
    logic [31:0]       dig_b;

    assign abs_a      = a[DW-1] ? DW'(-a) : DW'(a);
    assign abs_b      = b[DW-1] ? DW'(-b) : DW'(b);
    assign issue_last = (ia_reg == LAST_DIG) && (ib_reg == LAST_DIG);
    assign dig_a      = mag_a_reg[ia_reg*32 +: 32];
    assign dig_b      = mag_b_reg[ib_reg*32 +: 32];

    always_comb
    begin
        busy_next    = busy_reg;
        ia_next      = ia_reg;
        ib_next      = ib_reg;
        mag_a_next   = mag_a_reg;
        mag_b_next   = mag_b_reg;
        neg_next     = neg_reg;
        prod_next    = prod_reg;
        pshift_next  = pshift_reg;
        pvalid_next  = 1'b0;
        plast_next   = 1'b0;
        sign_next    = 1'b0;
        acc_next     = acc_reg;
        done_next    = 1'b0;
        product_next = product_reg;
        if (start)
        begin
            mag_a_next = MW'(abs_a);
            mag_b_next = MW'(abs_b);
            neg_next   = a[DW-1] ^ b[DW-1];
            busy_next  = 1'b1;
            ia_next    = '0;
            ib_next    = '0;
            acc_next   = '0;
        end
        else
        begin
            if (busy_reg)
            begin
                prod_next   = dig_a * dig_b;
                pshift_next = {1'b0, ia_reg} + {1'b0, ib_reg};
                pvalid_next = 1'b1;
                plast_next  = issue_last;
                if (ib_reg == LAST_DIG)
                begin
                    ib_next = '0;
                    ia_next = ia_reg + 1'b1;
                end
                else
                begin
                    ib_next = ib_reg + 1'b1;
                end
                if (issue_last)
                begin
                    busy_next = 1'b0;
                end
            end
            if (pvalid_reg)
            begin
                acc_next  = acc_reg + (AW'(prod_reg) << (pshift_reg * 32));
                sign_next = plast_reg;
            end
            if (sign_reg)
            begin
                product_next = neg_reg ? (-acc_reg[PW-1:0]) : acc_reg[PW-1:0];
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            pvalid_reg <= 1'b0;
            plast_reg  <= 1'b0;
            sign_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            pvalid_reg <= pvalid_next;
            plast_reg  <= plast_next;
            sign_reg   <= sign_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ia_reg      <= ia_next;
        ib_reg      <= ib_next;
        mag_a_reg   <= mag_a_next;
        mag_b_reg   <= mag_b_next;
        neg_reg     <= neg_next;
        prod_reg    <= prod_next;
        pshift_reg  <= pshift_next;
        acc_reg     <= acc_next;
        product_reg <= product_next;
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

[rtl/pip_cordic.sv]
module pip_cordic
    import pip_pkg::*;
#(
    parameter int CRW          = 67,
    parameter int CORDIC_STEPS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [CRW-1:0] cr_in,
    input  logic signed [CRW-1:0] dt_in,
    output cordic_res_t           res
);

    localparam int NW    = (CRW > CORDIC_W) ? CRW : CORDIC_W;
    localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

    cordic_state_t             state_reg, state_next;
    logic signed [NW-1:0]      cr_reg, cr_next;
    logic signed [NW-1:0]      dt_reg, dt_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic [31:0]               z_reg, z_next;
    logic [4:0]                step_reg, step_next;
    logic                      done_reg, done_next;
    logic [31:0]               angle_reg, angle_next;

    logic signed [NW-1:0]       cr_c;
    logic signed [NW-1:0]       dt_c;
    logic                       norm_done;
    logic                       coarse;
    logic signed [CORDIC_W-1:0] x0;
    logic signed [CORDIC_W-1:0] y0;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic                       dir;
    logic [31:0]                atan_v;

    function automatic logic fits(input logic signed [NW-1:0] v);
        logic [NW-NORM_LIMIT_BIT-1:0] hi;
        hi = v[NW-1:NORM_LIMIT_BIT];
        return (hi == '0) || (hi == '1);
    endfunction

    assign cr_c      = cr_reg >>> NORM_COARSE;
    assign dt_c      = dt_reg >>> NORM_COARSE;
    assign norm_done = fits(cr_reg) && fits(dt_reg);
    assign coarse    = !(fits(cr_c) && fits(dt_c));
    assign x0        = dt_reg[CORDIC_W-1:0];
    assign y0        = cr_reg[CORDIC_W-1:0];
    assign xs        = x_reg >>> step_reg;
    assign ys        = y_reg >>> step_reg;
    assign dir       = !y_reg[CORDIC_W-1] && (y_reg != '0);
    assign atan_v    = atan_entry(step_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = C_NORM;
                end
            end
            C_NORM:
            begin
                if (norm_done)
                begin
                    state_next = C_ROT;
                end
            end
            C_ROT:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cr_next    = cr_reg;
        dt_next    = dt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        angle_next = angle_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    cr_next = NW'(cr_in);
                    dt_next = NW'(dt_in);
                end
            end
            C_NORM:
            begin
                if (norm_done)
                begin
                    step_next = '0;
                    if (x0[CORDIC_W-1])
                    begin
                        x_next = -x0;
                        y_next = -y0;
                        z_next = 32'h80000000;
                    end
                    else
                    begin
                        x_next = x0;
                        y_next = y0;
                        z_next = '0;
                    end
                end
                else if (coarse)
                begin
                    cr_next = cr_c;
                    dt_next = dt_c;
                end
                else
                begin
                    cr_next = cr_reg >>> 1;
                    dt_next = dt_reg >>> 1;
                end
            end
            C_ROT:
            begin
                if (dir)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_v;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_v;
                end
                step_next = step_reg + 5'd1;
            end
            C_DONE:
            begin
                angle_next = z_reg[31] ? (-z_reg) : z_reg;
                done_next  = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cr_reg    <= cr_next;
        dt_reg    <= dt_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        step_reg  <= step_next;
        angle_reg <= angle_next;
    end

    assign res.done  = done_reg;
    assign res.angle = angle_reg;

endmodule

[rtl/point_in_polygon_winding_angle_core.sv]
// Query items load the query point and clear polygon state. A vertex item that is no corner forms
// its products from D*D digit products each, D = ceil((COORD_WIDTH+1)/32), and may run the CORDIC.
// After a closed polygon's final vertex, the decision and hand-over run through S_MAG, S_JUDGE, S_EMIT.
// Cost is set by the shared 32x32 multiplier (four exact products) and the
// one-iteration-per-cycle CORDIC. No new item is taken while a vertex is at work.
// rst_n (asynchronous, active low) clears query and polygon state, sets default tolerances.
module point_in_polygon_winding_angle_core
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH  = 32,
    parameter int CORDIC_STEPS = 24,
    parameter int SUM_WIDTH    = 40
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          op,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic                          last,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [2:0]                    status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int CRW = PW + 1;
    localparam logic [SUM_WIDTH-1:0] FULL_TURN = SUM_WIDTH'(64'h1_0000_0000);

    pip_state_t                state_reg, state_next;
    logic signed [CW-1:0]      query_x_reg, query_x_next;
    logic signed [CW-1:0]      query_y_reg, query_y_next;
    logic signed [CW-1:0]      first_x_reg, first_x_next;
    logic signed [CW-1:0]      first_y_reg, first_y_next;
    logic signed [CW-1:0]      prev_x_reg, prev_x_next;
    logic signed [CW-1:0]      prev_y_reg, prev_y_next;
    logic signed [CW-1:0]      cur_x_reg, cur_x_next;
    logic signed [CW-1:0]      cur_y_reg, cur_y_next;
    logic                      last_reg, last_next;
    logic                      have_first_reg, have_first_next;
    logic                      touch_reg, touch_next;
    logic [SUM_WIDTH-1:0]      sum_reg, sum_next;
    logic signed [DW-1:0]      ax_reg, ax_next;
    logic signed [DW-1:0]      ay_reg, ay_next;
    logic signed [DW-1:0]      bx_reg, bx_next;
    logic signed [DW-1:0]      by_reg, by_next;
    prod_sel_t                 sel_reg, sel_next;
    logic signed [CRW-1:0]     crs_reg, crs_next;
    logic signed [CRW-1:0]     dot_reg, dot_next;
    logic [SUM_WIDTH-1:0]      mag_reg, mag_next;
    logic [2:0]                pend_reg, pend_next;
    logic [2:0]                status_reg, status_next;
    logic                      result_valid_reg, result_valid_next;
    logic [15:0]               close_tol_reg;
    logic [30:0]               angle_tol_reg;

    logic                      item_accept;
    logic                      out_free;
    logic                      cfg_wr;
    logic                      mac_start;
    logic                      cordic_start;
    logic signed [DW-1:0]      mac_a;
    logic signed [DW-1:0]      mac_b;
    logic                      mac_done;
    logic signed [PW-1:0]      mac_prod;
    logic signed [CRW-1:0]     prod_ext;
    cordic_res_t               cordic_res;

    logic signed [CW-1:0]      end_x;
    logic signed [CW-1:0]      end_y;
    logic signed [DW-1:0]      set_ax;
    logic signed [DW-1:0]      set_ay;
    logic signed [DW-1:0]      set_bx;
    logic signed [DW-1:0]      set_by;
    logic signed [DW-1:0]      dfx;
    logic signed [DW-1:0]      dfy;
    logic [DW-1:0]             adfx;
    logic [DW-1:0]             adfy;
    logic                      open_poly;
    logic                      corner;
    pip_state_t                after_edge;
    logic [SUM_WIDTH-1:0]      ang_ext;
    logic [SUM_WIDTH-1:0]      dev;
    logic [SUM_WIDTH-1:0]      tol_ext;

    assign item_accept = item_valid && !item_stall;
    assign out_free    = !result_valid_reg || !result_stall;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign pready      = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_tol_reg <= CLOSE_TOL_RESET;
            angle_tol_reg <= ANGLE_TOL_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_CLOSE_TOL: close_tol_reg <= pwdata[15:0];
                REG_ANGLE_TOL: angle_tol_reg <= pwdata[30:0];
                default:       close_tol_reg <= close_tol_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CLOSE_TOL: prdata = {16'd0, close_tol_reg};
            REG_ANGLE_TOL: prdata = {1'b0, angle_tol_reg};
            default:       prdata = '0;
        endcase
    end

    // edge set-up terms
    assign end_x  = last_reg ? first_x_reg : cur_x_reg;
    assign end_y  = last_reg ? first_y_reg : cur_y_reg;
    assign set_ax = {prev_x_reg[CW-1], prev_x_reg} - {query_x_reg[CW-1], query_x_reg};
    assign set_ay = {prev_y_reg[CW-1], prev_y_reg} - {query_y_reg[CW-1], query_y_reg};
    assign set_bx = {end_x[CW-1], end_x} - {query_x_reg[CW-1], query_x_reg};
    assign set_by = {end_y[CW-1], end_y} - {query_y_reg[CW-1], query_y_reg};
    assign dfx    = {first_x_reg[CW-1], first_x_reg} - {cur_x_reg[CW-1], cur_x_reg};
    assign dfy    = {first_y_reg[CW-1], first_y_reg} - {cur_y_reg[CW-1], cur_y_reg};
    assign adfx   = dfx[DW-1] ? DW'(-dfx) : DW'(dfx);
    assign adfy   = dfy[DW-1] ? DW'(-dfy) : DW'(dfy);
    assign open_poly = last_reg &&
                       ((adfx > DW'(close_tol_reg)) || (adfy > DW'(close_tol_reg)));
    assign corner = ((set_ax == '0) && (set_ay == '0)) || ((set_bx == '0) && (set_by == '0));
    assign after_edge = last_reg ? S_MAG : S_IDLE;

    assign prod_ext = {mac_prod[PW-1], mac_prod};
    assign ang_ext  = SUM_WIDTH'(cordic_res.angle);
    assign tol_ext  = SUM_WIDTH'(angle_tol_reg);
    assign dev      = (mag_reg >= FULL_TURN) ? (mag_reg - FULL_TURN) : (FULL_TURN - mag_reg);

    always_comb
    begin
        case (sel_reg)
            PROD_AX_BY:
            begin
                mac_a = ax_reg;
                mac_b = by_reg;
            end
            PROD_BX_AY:
            begin
                mac_a = bx_reg;
                mac_b = ay_reg;
            end
            PROD_AX_BX:
            begin
                mac_a = ax_reg;
                mac_b = bx_reg;
            end
            default:
            begin
                mac_a = ay_reg;
                mac_b = by_reg;
            end
        endcase
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept && (op == OP_VERTEX))
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (open_poly)
                begin
                    state_next = S_EMIT;
                end
                else if (corner)
                begin
                    state_next = after_edge;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (mac_done)
                begin
                    state_next = (sel_reg == PROD_AY_BY) ? S_CHECK : S_MUL;
                end
            end
            S_CHECK:
            begin
                state_next = (crs_reg == '0) ? after_edge : S_ANGLE;
            end
            S_ANGLE:
            begin
                if (cordic_res.done)
                begin
                    state_next = after_edge;
                end
            end
            S_MAG:
            begin
                state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        item_stall   = 1'b1;
        mac_start    = 1'b0;
        cordic_start = 1'b0;
        unique case (state_reg)
            S_IDLE:  item_stall   = 1'b0;
            S_MUL:   mac_start    = 1'b1;
            S_CHECK: cordic_start = (crs_reg != '0);
            default: item_stall   = 1'b1;
        endcase
    end

    // datapath
    always_comb
    begin
        query_x_next      = query_x_reg;
        query_y_next      = query_y_reg;
        first_x_next      = first_x_reg;
        first_y_next      = first_y_reg;
        prev_x_next       = prev_x_reg;
        prev_y_next       = prev_y_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        last_next         = last_reg;
        have_first_next   = have_first_reg;
        touch_next        = touch_reg;
        sum_next          = sum_reg;
        ax_next           = ax_reg;
        ay_next           = ay_reg;
        bx_next           = bx_reg;
        by_next           = by_reg;
        sel_next          = sel_reg;
        crs_next          = crs_reg;
        dot_next          = dot_reg;
        mag_next          = mag_reg;
        pend_next         = pend_reg;
        status_next       = status_reg;
        result_valid_next = result_valid_reg && result_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    if (op == OP_QUERY)
                    begin
                        query_x_next    = coord_x;
                        query_y_next    = coord_y;
                        have_first_next = 1'b0;
                        touch_next      = 1'b0;
                        sum_next        = '0;
                    end
                    else
                    begin
                        cur_x_next = coord_x;
                        cur_y_next = coord_y;
                        last_next  = last;
                        if (!have_first_reg)
                        begin
                            first_x_next    = coord_x;
                            first_y_next    = coord_y;
                            prev_x_next     = coord_x;
                            prev_y_next     = coord_y;
                            have_first_next = 1'b1;
                        end
                    end
                end
            end
            S_SETUP:
            begin
                ax_next  = set_ax;
                ay_next  = set_ay;
                bx_next  = set_bx;
                by_next  = set_by;
                sel_next = PROD_AX_BY;
                if (!last_reg)
                begin
                    prev_x_next = cur_x_reg;
                    prev_y_next = cur_y_reg;
                end
                if (open_poly)
                begin
                    pend_next = STATUS_NOT_CLOSED;
                end
                else if (corner)
                begin
                    touch_next = 1'b1;
                end
            end
            S_MWAIT:
            begin
                if (mac_done)
                begin
                    case (sel_reg)
                        PROD_AX_BY: crs_next = prod_ext;
                        PROD_BX_AY: crs_next = crs_reg - prod_ext;
                        PROD_AX_BX: dot_next = prod_ext;
                        default:    dot_next = dot_reg + prod_ext;
                    endcase
                    sel_next = prod_sel_t'(sel_reg + 2'd1);
                end
            end
            S_CHECK:
            begin
                if ((crs_reg == '0) && dot_reg[CRW-1])
                begin
                    touch_next = 1'b1;
                end
            end
            S_ANGLE:
            begin
                if (cordic_res.done)
                begin
                    sum_next = crs_reg[CRW-1] ? (sum_reg - ang_ext) : (sum_reg + ang_ext);
                end
            end
            S_MAG:
            begin
                mag_next = sum_reg[SUM_WIDTH-1] ? (-sum_reg) : sum_reg;
            end
            S_JUDGE:
            begin
                if (touch_reg)
                begin
                    pend_next = STATUS_TOUCH;
                end
                else if (dev <= tol_ext)
                begin
                    pend_next = STATUS_INSIDE;
                end
                else if (mag_reg <= tol_ext)
                begin
                    pend_next = STATUS_OUTSIDE;
                end
                else
                begin
                    pend_next = STATUS_UNDET;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    status_next       = pend_reg;
                    result_valid_next = 1'b1;
                    have_first_next   = 1'b0;
                    touch_next        = 1'b0;
                    sum_next          = '0;
                end
            end
            default:
            begin
                touch_next = touch_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            query_x_reg      <= '0;
            query_y_reg      <= '0;
            first_x_reg      <= '0;
            first_y_reg      <= '0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            have_first_reg   <= 1'b0;
            touch_reg        <= 1'b0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            query_x_reg      <= query_x_next;
            query_y_reg      <= query_y_next;
            first_x_reg      <= first_x_next;
            first_y_reg      <= first_y_next;
            prev_x_reg       <= prev_x_next;
            prev_y_reg       <= prev_y_next;
            have_first_reg   <= have_first_next;
            touch_reg        <= touch_next;
            sum_reg          <= sum_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        last_reg   <= last_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        sel_reg    <= sel_next;
        crs_reg    <= crs_next;
        dot_reg    <= dot_next;
        mag_reg    <= mag_next;
        pend_reg   <= pend_next;
        status_reg <= status_next;
    end

    pip_mac #(
        .DW (DW)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mac_start),
        .a       (mac_a),
        .b       (mac_b),
        .done    (mac_done),
        .product (mac_prod)
    );

    pip_cordic #(
        .CRW          (CRW),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .cr_in (crs_reg),
        .dt_in (dot_reg),
        .res   (cordic_res)
    );

    assign result_valid = result_valid_reg;
    assign status       = status_reg;

    a_mac_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == S_MWAIT))
        else $error("product returned outside the product wait state");

    a_cordic_done_in_angle: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_res.done |-> (state_reg == S_ANGLE))
        else $error("angle returned outside the angle wait state");

    a_query_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && (op == OP_QUERY)) |=>
            ((sum_reg == '0) && !touch_reg && !have_first_reg))
        else $error("query item left polygon state behind");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status <= STATUS_NOT_CLOSED))
        else $error("result status out of range");

endmodule
